@@ src/imsu_pkg.sv @@
// shared types and constants for the ising metropolis spin update block
`timescale 1ns / 1ps

package imsu_pkg;

    // apb configuration port
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // register indexes, at byte address 8*index
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_UP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR_DN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AA_MASK = 3'd4;

    // field widths
    localparam int SIZE_W    = 7;
    localparam int ROW_W     = 6;
    localparam int COL_W     = 6;
    localparam int DRAW_W    = 12;
    localparam int SUM_W     = 4;
    localparam int THR_REG_W = 60;
    localparam int NUM_CASES = 5;
    localparam int MASK_W    = 2 * NUM_CASES;

    // register reset values
    localparam logic [SIZE_W-1:0] ROWS_RESET = 7'd64;
    localparam logic [SIZE_W-1:0] COLS_RESET = 7'd64;

    // configuration register file contents
    typedef struct packed {
        logic [SIZE_W-1:0]    rows;
        logic [SIZE_W-1:0]    cols;
        logic [THR_REG_W-1:0] thr_up;
        logic [THR_REG_W-1:0] thr_dn;
        logic [MASK_W-1:0]    aa_mask;
    } cfg_regs_t;

    // controller to datapath commands
    typedef struct packed {
        logic clr_wr;    // write one all-plus row during the clearing pass
        logic cap_item;  // register the input item on a transfer
        logic addr_row;  // port a reads the site row instead of the row above
        logic latch_nb;  // keep the up and down neighbor spins
        logic calc;      // decide, write back and load the result register
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;  // clearing pass is on its last row
        logic out_full;  // result register holds an untaken result
    } ctrl_sts_t;

endpackage

@@ src/ising_metropolis_spin_update.sv @@
// top level of the 2d ising lattice metropolis spin update block
//
//  channel   signals                                        direction
//  -------   ---------------------------------------------  ---------
//  apb       psel penable pwrite paddr pwdata prdata pready  in/out
//  input     in_valid in_ready mode row col spin_value       in
//            random_draw
//  output    out_valid out_ready spin flipped neighbor_sum   out
//            bad_site
//
// each item goes from its transfer to its result in the output register
// through two registered reads of the row memory (neighbor rows, then the
// site row) and a step that decides and writes the row back.
// a new item is taken only once the previous one has been decided; a result
// left waiting holds back only the decide step of the following item.
// after reset a clearing pass writes MAX_ROWS all-plus rows with in_ready
// low; configuration writes are taken at any time.
`timescale 1ns / 1ps

module ising_metropolis_spin_update
    import imsu_pkg::*;
#(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int PROB_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    mode,
    input  logic [ROW_W-1:0]        row,
    input  logic [COL_W-1:0]        col,
    input  logic                    spin_value,
    input  logic [DRAW_W-1:0]       random_draw,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    spin,
    output logic                    flipped,
    output logic signed [SUM_W-1:0] neighbor_sum,
    output logic                    bad_site
);

    cfg_regs_t cfg;
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // configuration registers
    imsu_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // controller
    imsu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    imsu_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .PROB_BITS (PROB_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .row          (row),
        .col          (col),
        .spin_value   (spin_value),
        .random_draw  (random_draw),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .spin         (spin),
        .flipped      (flipped),
        .neighbor_sum (neighbor_sum),
        .bad_site     (bad_site)
    );

    // one item in flight: no new transfer right after one is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    // the decide step never overwrites a waiting result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.calc |-> !(out_valid && !out_ready))
        else $error("result register overwritten");

    // a bad site reports nothing else
    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_site |-> !spin && !flipped && neighbor_sum == '0)
        else $error("bad site result carries data");

    // the clearing pass never overlaps an item
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_wr |-> !in_ready && !cmd.calc)
        else $error("clearing pass overlaps an item");

endmodule

@@ src/imsu_ram.sv @@
// generic single write, dual read memory with registered read data
`timescale 1ns / 1ps

module imsu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // two registered read ports
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ src/imsu_cfg.sv @@
// apb configuration registers for the spin update block
`timescale 1ns / 1ps

module imsu_cfg
    import imsu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_regs_t             cfg
);

    cfg_regs_t            cfg_reg;
    cfg_regs_t            cfg_next;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[APB_ADDR_W-1:APB_ADDR_W-CFG_IDX_W];
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ROWS:    cfg_next.rows    = pwdata[SIZE_W-1:0];
                REG_COLS:    cfg_next.cols    = pwdata[SIZE_W-1:0];
                REG_THR_UP:  cfg_next.thr_up  = pwdata[THR_REG_W-1:0];
                REG_THR_DN:  cfg_next.thr_dn  = pwdata[THR_REG_W-1:0];
                REG_AA_MASK: cfg_next.aa_mask = pwdata[MASK_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows    <= ROWS_RESET;
            cfg_reg.cols    <= COLS_RESET;
            cfg_reg.thr_up  <= '0;
            cfg_reg.thr_dn  <= '0;
            cfg_reg.aa_mask <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // register read mux
    always_comb
    begin
        case (idx)
            REG_ROWS:    prdata = APB_DATA_W'(cfg_reg.rows);
            REG_COLS:    prdata = APB_DATA_W'(cfg_reg.cols);
            REG_THR_UP:  prdata = APB_DATA_W'(cfg_reg.thr_up);
            REG_THR_DN:  prdata = APB_DATA_W'(cfg_reg.thr_dn);
            REG_AA_MASK: prdata = APB_DATA_W'(cfg_reg.aa_mask);
            default:     prdata = '0;
        endcase
    end

endmodule

@@ src/imsu_ctrl.sv @@
// sequencer for the clearing pass and the per-site read, decide, write steps
`timescale 1ns / 1ps

module imsu_ctrl
    import imsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ctrl_sts_t  sts,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RDNB  = 3'd2;
    localparam logic [2:0] S_RDROW = 3'd3;
    localparam logic [2:0] S_CALC  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap_item = 1'b1;
                    state_next   = S_RDNB;
                end
            end
            S_RDNB:
            begin
                state_next = S_RDROW;
            end
            S_RDROW:
            begin
                cmd.addr_row = 1'b1;
                cmd.latch_nb = 1'b1;
                state_next   = S_CALC;
            end
            S_CALC:
            begin
                cmd.addr_row = 1'b1;
                if (!sts.out_full)
                begin
                    cmd.calc   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/imsu_datapath.sv @@
// lattice row memory, neighbor addressing, acceptance decision and result register
`timescale 1ns / 1ps

module imsu_datapath
    import imsu_pkg::*;
#(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int PROB_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_regs_t               cfg,
    input  ctrl_cmd_t               cmd,
    output ctrl_sts_t               sts,
    input  logic                    mode,
    input  logic [ROW_W-1:0]        row,
    input  logic [COL_W-1:0]        col,
    input  logic                    spin_value,
    input  logic [DRAW_W-1:0]       random_draw,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    spin,
    output logic                    flipped,
    output logic signed [SUM_W-1:0] neighbor_sum,
    output logic                    bad_site
);

    localparam int RA    = $clog2(MAX_ROWS);
    localparam int CA    = $clog2(MAX_COLS);
    localparam int EXT_W = (NUM_CASES * PROB_BITS > THR_REG_W) ? NUM_CASES * PROB_BITS
                                                               : THR_REG_W;
    localparam int CMP_W = (PROB_BITS > DRAW_W) ? PROB_BITS : DRAW_W;
    localparam logic [CMP_W-1:0] DRAW_MASK = CMP_W'((64'd1 << PROB_BITS) - 64'd1);
    localparam logic [10:0] MAX_R11 = 11'(MAX_ROWS);
    localparam logic [10:0] MAX_C11 = 11'(MAX_COLS);
    localparam logic [RA-1:0] LAST_ROW = RA'(MAX_ROWS - 1);

    // item registers
    logic              mode_reg, mode_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              sval_reg, sval_next;
    logic [DRAW_W-1:0] draw_reg, draw_next;

    // neighbor spins from the rows above and below
    logic up_bit_reg, up_bit_next;
    logic dn_bit_reg, dn_bit_next;

    // clearing pass row counter
    logic [RA-1:0] clr_cnt_reg, clr_cnt_next;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic             spin_reg, spin_next;
    logic             flipped_reg, flipped_next;
    logic [SUM_W-1:0] nsum_reg, nsum_next;
    logic             bad_reg, bad_next;

    // combinational datapath
    logic [SIZE_W-1:0]   nr, nc;
    logic [SIZE_W-1:0]   row7, col7, up7, dn7, lf7, rt7;
    logic                bad;
    logic [RA-1:0]       row_idx, up_idx, dn_idx;
    logic [CA-1:0]       col_idx, lf_idx, rt_idx;
    logic                ram_we;
    logic [RA-1:0]       ram_waddr, ram_raddr_a;
    logic [MAX_COLS-1:0] ram_wdata, rdata_a, rdata_b, row_new;
    logic                cur, lf_bit, rt_bit, plus;
    logic [2:0]          ones;
    logic [3:0]          aa_idx;
    logic                always_flip, draw_below, flip, new_spin;
    logic [EXT_W-1:0]    thr_ext;
    logic [PROB_BITS-1:0] thr;
    logic [CMP_W-1:0]    draw_m;
    logic [SUM_W-1:0]    sum;

    // sizes in use, saturated to the lattice dimensions
    always_comb
    begin
        nr = (11'(cfg.rows) > MAX_R11) ? SIZE_W'(MAX_ROWS) : cfg.rows;
        nc = (11'(cfg.cols) > MAX_C11) ? SIZE_W'(MAX_COLS) : cfg.cols;
    end

    // wrapped neighbor coordinates
    always_comb
    begin
        row7 = SIZE_W'(row_reg);
        col7 = SIZE_W'(col_reg);
        bad  = (row7 >= nr) | (col7 >= nc);
        up7  = (row7 == '0) ? nr - 7'd1 : row7 - 7'd1;
        dn7  = (row7 + 7'd1 == nr) ? '0 : row7 + 7'd1;
        lf7  = (col7 == '0) ? nc - 7'd1 : col7 - 7'd1;
        rt7  = (col7 + 7'd1 == nc) ? '0 : col7 + 7'd1;
        row_idx = RA'(row7);
        up_idx  = RA'(up7);
        dn_idx  = RA'(dn7);
        col_idx = CA'(col7);
        lf_idx  = CA'(lf7);
        rt_idx  = CA'(rt7);
    end

    // spins of the site row and the neighbor count
    always_comb
    begin
        cur    = rdata_a[col_idx];
        lf_bit = rdata_a[lf_idx];
        rt_bit = rdata_a[rt_idx];
        ones   = 3'(up_bit_reg) + 3'(dn_bit_reg) + 3'(lf_bit) + 3'(rt_bit);
        sum    = SUM_W'({ones, 1'b0}) - 4'd4;
        plus   = cur;
    end

    // metropolis acceptance
    always_comb
    begin
        aa_idx      = plus ? 4'(ones) : 4'(ones) + 4'd5;
        always_flip = cfg.aa_mask[aa_idx];
        thr_ext     = plus ? EXT_W'(cfg.thr_up) : EXT_W'(cfg.thr_dn);
        thr         = thr_ext[ones * PROB_BITS +: PROB_BITS];
        draw_m      = CMP_W'(draw_reg) & DRAW_MASK;
        draw_below  = (draw_m < CMP_W'(thr));
        flip        = mode_reg & (always_flip | draw_below);
        new_spin    = mode_reg ? (cur ^ flip) : sval_reg;
        row_new          = rdata_a;
        row_new[col_idx] = new_spin;
    end

    // memory ports
    always_comb
    begin
        ram_we      = cmd.clr_wr | (cmd.calc & ~bad);
        ram_waddr   = cmd.clr_wr ? clr_cnt_reg : row_idx;
        ram_wdata   = cmd.clr_wr ? '1 : row_new;
        ram_raddr_a = cmd.addr_row ? row_idx : up_idx;
    end

    imsu_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_lattice (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (dn_idx),
        .rdata_b (rdata_b)
    );

    // next values of the registers
    always_comb
    begin
        mode_next      = mode_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        sval_next      = sval_reg;
        draw_next      = draw_reg;
        up_bit_next    = up_bit_reg;
        dn_bit_next    = dn_bit_reg;
        clr_cnt_next   = clr_cnt_reg;
        spin_next      = spin_reg;
        flipped_next   = flipped_reg;
        nsum_next      = nsum_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg & ~out_ready;

        if (cmd.cap_item)
        begin
            mode_next = mode;
            row_next  = row;
            col_next  = col;
            sval_next = spin_value;
            draw_next = random_draw;
        end

        if (cmd.latch_nb)
        begin
            up_bit_next = rdata_a[col_idx];
            dn_bit_next = rdata_b[col_idx];
        end

        if (cmd.clr_wr)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end

        if (cmd.calc)
        begin
            out_valid_next = 1'b1;
            spin_next      = ~bad & new_spin;
            flipped_next   = ~bad & flip;
            nsum_next      = bad ? '0 : sum;
            bad_next       = bad;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        sval_reg    <= sval_next;
        draw_reg    <= draw_next;
        up_bit_reg  <= up_bit_next;
        dn_bit_reg  <= dn_bit_next;
        spin_reg    <= spin_next;
        flipped_reg <= flipped_next;
        nsum_reg    <= nsum_next;
        bad_reg     <= bad_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.clr_last  = (clr_cnt_reg == LAST_ROW);
    assign sts.out_full  = out_valid_reg & ~out_ready;
    assign out_valid     = out_valid_reg;
    assign spin          = spin_reg;
    assign flipped       = flipped_reg;
    assign neighbor_sum  = nsum_reg;
    assign bad_site      = bad_reg;

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for the ising metropolis spin update block
`timescale 1ns / 1ps

module testbench;
    import imsu_pkg::*;

    localparam int LAT_ROWS = 64;
    localparam int LAT_COLS = 64;
    localparam int PROB_W   = 12;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    // one expected result transfer
    typedef struct packed {
        logic              spin;
        logic              flipped;
        logic signed [3:0] nsum;
        logic              bad;
    } site_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_ready;
    logic                    mode;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic                    spin_value;
    logic [DRAW_W-1:0]       random_draw;
    logic                    out_valid;
    logic                    out_ready;
    logic                    spin;
    logic                    flipped;
    logic signed [SUM_W-1:0] neighbor_sum;
    logic                    bad_site;

    // shadow of the lattice and the configuration registers
    logic         spin_grid [LAT_ROWS][LAT_COLS];
    cfg_regs_t    shadow_cfg;
    site_result_t expected_sites [$];
    int           error_count;
    bit           steady_flow;

    ising_metropolis_spin_update DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .row          (row),
        .col          (col),
        .spin_value   (spin_value),
        .random_draw  (random_draw),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .spin         (spin),
        .flipped      (flipped),
        .neighbor_sum (neighbor_sum),
        .bad_site     (bad_site)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // run limit
    initial
    begin
        #4_000_000;
        $display("[ising_metropolis_spin_update] ERROR");
        $finish;
    end

    // spin as +1 or -1
    function automatic int spin_pm(int r, int c);
        return spin_grid[r][c] ? 1 : -1;
    endfunction

    // metropolis step on the shadow lattice
    function automatic site_result_t update_site(logic m, logic [ROW_W-1:0] r,
                                                 logic [COL_W-1:0] c, logic sv,
                                                 logic [DRAW_W-1:0] d);
        site_result_t         res;
        int                   nr;
        int                   nc;
        int                   up;
        int                   dn;
        int                   lf;
        int                   rt;
        int                   sum;
        int                   k;
        logic                 plus;
        logic                 take_always;
        logic [THR_REG_W-1:0] thr_reg;
        logic [PROB_W-1:0]    thr;
        res = '0;
        // sizes above the lattice saturate
        nr = (shadow_cfg.rows > LAT_ROWS) ? LAT_ROWS : int'(shadow_cfg.rows);
        nc = (shadow_cfg.cols > LAT_COLS) ? LAT_COLS : int'(shadow_cfg.cols);
        if (int'(r) >= nr || int'(c) >= nc)
        begin
            res.bad = 1'b1;
            return res;
        end
        // wrapped neighbors
        up = (r == 0) ? nr - 1 : int'(r) - 1;
        dn = (int'(r) + 1 == nr) ? 0 : int'(r) + 1;
        lf = (c == 0) ? nc - 1 : int'(c) - 1;
        rt = (int'(c) + 1 == nc) ? 0 : int'(c) + 1;
        sum = spin_pm(up, int'(c)) + spin_pm(dn, int'(c)) + spin_pm(int'(r), lf)
            + spin_pm(int'(r), rt);
        res.nsum = sum[3:0];
        if (m == MODE_LOAD)
        begin
            spin_grid[r][c] = sv;
        end
        else
        begin
            k = (sum + 4) / 2;
            plus = spin_grid[r][c];
            take_always = shadow_cfg.aa_mask[k + (plus ? 0 : NUM_CASES)];
            thr_reg = plus ? shadow_cfg.thr_up : shadow_cfg.thr_dn;
            thr = thr_reg[k*PROB_W +: PROB_W];
            if (take_always || d < thr)
            begin
                spin_grid[r][c] = ~plus;
                res.flipped = 1'b1;
            end
        end
        res.spin = spin_grid[r][c];
        return res;
    endfunction

    // apb register write: setup, then access, then idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ROWS:    shadow_cfg.rows    = value[SIZE_W-1:0];
            REG_COLS:    shadow_cfg.cols    = value[SIZE_W-1:0];
            REG_THR_UP:  shadow_cfg.thr_up  = value[THR_REG_W-1:0];
            REG_THR_DN:  shadow_cfg.thr_dn  = value[THR_REG_W-1:0];
            REG_AA_MASK: shadow_cfg.aa_mask = value[MASK_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // one input transfer, prediction taken at the handshake
    task automatic send_item(input logic m, input logic [ROW_W-1:0] r,
                             input logic [COL_W-1:0] c, input logic sv,
                             input logic [DRAW_W-1:0] d);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        row         <= r;
        col         <= c;
        spin_value  <= sv;
        random_draw <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_sites.push_back(update_site(m, r, c, sv, d));
    endtask

    // drop valid and let every result drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_sites.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // reset state, corner sites, a load next to an update
    task automatic test_defaults();
        send_item(MODE_UPDATE, 6'd0, 6'd0, 1'b0, 12'd0);
        send_item(MODE_UPDATE, 6'd63, 6'd63, 1'b1, 12'hFFF);
        send_item(MODE_LOAD, 6'd31, 6'd17, 1'b0, 12'hABC);
        send_item(MODE_UPDATE, 6'd31, 6'd18, 1'b0, 12'd0);
        send_item(MODE_LOAD, 6'd0, 6'd0, 1'b1, 12'hFFF);
        wait_idle();
    endtask

    // always-accept bits for both spin signs
    task automatic test_always_accept();
        cfg_write(REG_AA_MASK, 64'h3FF);
        send_item(MODE_UPDATE, 6'd5, 6'd5, 1'b0, 12'hFFF);
        send_item(MODE_UPDATE, 6'd5, 6'd5, 1'b1, 12'hFFF);
        wait_idle();
        cfg_write(REG_AA_MASK, 64'h0);
    endtask

    // strict less-than at the top of the threshold range
    task automatic test_threshold_compare();
        cfg_write(REG_THR_UP, 64'h0FFF_FFFF_FFFF_FFFF);
        cfg_write(REG_THR_DN, 64'h0FFF_FFFF_FFFF_FFFF);
        send_item(MODE_UPDATE, 6'd10, 6'd10, 1'b0, 12'hFFF);
        send_item(MODE_UPDATE, 6'd10, 6'd10, 1'b0, 12'hFFE);
        send_item(MODE_UPDATE, 6'd10, 6'd10, 1'b0, 12'hFFF);
        send_item(MODE_UPDATE, 6'd10, 6'd10, 1'b0, 12'd0);
        wait_idle();
        cfg_write(REG_THR_UP, 64'h0);
        cfg_write(REG_THR_DN, 64'h0);
    endtask

    // size one wraps onto itself, size zero, oversized saturates
    task automatic test_lattice_sizes();
        cfg_write(REG_ROWS, 64'd1);
        cfg_write(REG_COLS, 64'd1);
        send_item(MODE_UPDATE, 6'd0, 6'd0, 1'b0, 12'd7);
        send_item(MODE_LOAD, 6'd0, 6'd0, 1'b0, 12'd0);
        send_item(MODE_UPDATE, 6'd0, 6'd0, 1'b1, 12'd0);
        send_item(MODE_UPDATE, 6'd0, 6'd1, 1'b1, 12'd0);
        send_item(MODE_LOAD, 6'd1, 6'd0, 1'b1, 12'd0);
        wait_idle();
        cfg_write(REG_ROWS, 64'd0);
        send_item(MODE_UPDATE, 6'd0, 6'd0, 1'b1, 12'd0);
        wait_idle();
        cfg_write(REG_ROWS, 64'd127);
        cfg_write(REG_COLS, 64'd127);
        send_item(MODE_UPDATE, 6'd63, 6'd63, 1'b0, 12'd1);
        send_item(MODE_LOAD, 6'd63, 6'd0, 1'b0, 12'd0);
        wait_idle();
        cfg_write(REG_ROWS, 64'd64);
        cfg_write(REG_COLS, 64'd64);
    endtask

    // random sites and draws over several configurations
    task automatic test_random_sweeps();
        int                   nr;
        int                   nc;
        int                   sel;
        logic [ROW_W-1:0]     r;
        logic [COL_W-1:0]     c;
        logic [THR_REG_W-1:0] thr;
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            // small lattices keep neighbor sums varied
            case (phase)
                0:
                begin
                    nr = 64;
                    nc = 64;
                end
                5:
                begin
                    nr = 1;
                    nc = 64;
                end
                default:
                begin
                    nr = $urandom_range(2, 8);
                    nc = $urandom_range(2, 8);
                end
            endcase
            cfg_write(REG_ROWS, 64'(nr));
            cfg_write(REG_COLS, 64'(nc));
            thr = THR_REG_W'({$urandom, $urandom});
            cfg_write(REG_THR_UP, 64'(thr));
            thr = THR_REG_W'({$urandom, $urandom});
            cfg_write(REG_THR_DN, 64'(thr));
            cfg_write(REG_AA_MASK, 64'($urandom_range(0, 1023)));
            steady_flow = (phase == 2);
            for (int n = 0; n < 210; n++)
            begin
                // most sites in range, some anywhere
                sel = $urandom_range(0, 9);
                r = (sel == 0) ? ROW_W'($urandom_range(0, 63)) : ROW_W'($urandom_range(0, nr - 1));
                c = (sel == 0) ? COL_W'($urandom_range(0, 63)) : COL_W'($urandom_range(0, nc - 1));
                send_item(($urandom_range(0, 9) < 3) ? MODE_LOAD : MODE_UPDATE, r, c,
                          1'($urandom_range(0, 1)), DRAW_W'($urandom_range(0, 4095)));
            end
            steady_flow = 1'b0;
        end
        wait_idle();
    endtask

    // result side stalls
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin : check_results
        site_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_sites.size() == 0)
            begin
                $error("result transfer with no prediction waiting");
                error_count++;
            end
            else
            begin
                want = expected_sites.pop_front();
                if (spin !== want.spin)
                begin
                    $error("spin: expected %0d, got %0d", want.spin, spin);
                    error_count++;
                end
                if (flipped !== want.flipped)
                begin
                    $error("flipped: expected %0d, got %0d", want.flipped, flipped);
                    error_count++;
                end
                if (neighbor_sum !== want.nsum)
                begin
                    $error("neighbor_sum: expected %0d, got %0d", want.nsum, neighbor_sum);
                    error_count++;
                end
                if (bad_site !== want.bad)
                begin
                    $error("bad_site: expected %0d, got %0d", want.bad, bad_site);
                    error_count++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        mode        = MODE_LOAD;
        row         = '0;
        col         = '0;
        spin_value  = 1'b0;
        random_draw = '0;
        error_count = 0;
        steady_flow = 1'b0;
        shadow_cfg  = '0;
        shadow_cfg.rows = ROWS_RESET;
        shadow_cfg.cols = COLS_RESET;
        foreach (spin_grid[r, c])
            spin_grid[r][c] = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_always_accept();
        test_threshold_compare();
        test_lattice_sizes();
        test_random_sweeps();
        if (error_count == 0)
            $display("[ising_metropolis_spin_update] OK");
        else
            $display("[ising_metropolis_spin_update] ERROR");
        $finish;
    end

endmodule
